// ===== rtl/pcdf_pkg.sv =====
package pcdf_pkg;

  localparam int DEFAULT_TABLE_DEPTH   = 1024;
  localparam int DEFAULT_FRACTION_BITS = 16;
  localparam int QUEUE_DEPTH           = 2;

  localparam int IDX_W  = 10;
  localparam int POS_W  = 32;
  localparam int CDF_W  = 17;
  localparam int INV_W  = 32;
  localparam int RAND_W = 16;
  localparam int CNT_W  = 11;

  // Request kind, coded as the action field of the request.
  typedef enum logic [0:0] {
    KIND_LOAD = 1'b0,
    KIND_DRAW = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [IDX_W-1:0]   index;
    logic [POS_W-1:0]   position;
    logic [CDF_W-1:0]   cdf;
    logic [INV_W-1:0]   inv_step;
    logic [RAND_W-1:0]  rnd;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } qitem_t;

endpackage

// ===== rtl/pcdf_front.sv =====
module pcdf_front
  import pcdf_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              action_i,
  input  logic [IDX_W-1:0]  entry_index_i,
  input  logic [POS_W-1:0]  entry_position_i,
  input  logic [CDF_W-1:0]  entry_cdf_i,
  input  logic [INV_W-1:0]  entry_inverse_step_i,
  input  logic [RAND_W-1:0] random_value_i,
  output qitem_t            q_o,
  input  logic              q_ready_i
);

  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  req_t           fifo_q [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0] count_q;

  req_t  new_req;
  kind_e kind;
  logic  accept, in_range, push, pop;

  assign accept   = start && !busy;
  assign kind     = kind_e'(action_i);
  assign in_range = 32'(entry_index_i) < 32'(TABLE_DEPTH);
  // Drop loads aimed beyond the table; keep every draw.
  assign push     = accept && ((kind == KIND_DRAW) || in_range);
  assign pop      = q_o.valid && q_ready_i;
  assign busy     = (count_q == QCW'(QUEUE_DEPTH));

  always_comb begin
    new_req.kind     = kind;
    new_req.index    = entry_index_i;
    new_req.position = entry_position_i;
    new_req.cdf      = entry_cdf_i;
    new_req.inv_step = entry_inverse_step_i;
    new_req.rnd      = random_value_i;
  end

  assign q_o.valid = (count_q != '0);
  assign q_o.req   = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= new_req;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> q_o.valid)
    else $error("pushed request not visible to back end");

  a_last_pop_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == QCW'(1)) && pop && !push |=> !q_o.valid)
    else $error("queue not empty after last pop");

endmodule

// ===== rtl/pcdf_back.sv =====
module pcdf_back
  import pcdf_pkg::*;
#(
  parameter int TABLE_DEPTH   = DEFAULT_TABLE_DEPTH,
  parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qitem_t            q_i,
  output logic              q_ready_o,
  input  logic [CNT_W-1:0]  entries_in_use_i,
  output logic              done_o,
  output logic [POS_W-1:0]  sample_value_o,
  output logic [POS_W-1:0]  range_low_o,
  output logic [POS_W-1:0]  range_high_o,
  output logic              table_valid_o
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int P1W   = RAND_W + INV_W;
  localparam int P2W   = FRACTION_BITS + POS_W + 3;
  localparam int SHIFT = 32 - FRACTION_BITS;
  localparam logic [FRACTION_BITS:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [CDF_W-1:0] cdf;
    logic [INV_W-1:0] inv_step;
  } entry_t;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_SRCH = 10'b00_0000_0010,
    S_CMP  = 10'b00_0000_0100,
    S_RD0  = 10'b00_0000_1000,
    S_RD1  = 10'b00_0001_0000,
    S_RD2  = 10'b00_0010_0000,
    S_RD3  = 10'b00_0100_0000,
    S_MUL1 = 10'b00_1000_0000,
    S_MUL2 = 10'b01_0000_0000,
    S_OUT  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  entry_t mem_q [TABLE_DEPTH];
  entry_t rd_q;
  entry_t mem_wdata;
  logic [AW-1:0] mem_addr;
  logic          mem_we;

  logic [CW-1:0]     lo_q, hi_q, mid_q, n_q, idx_q;
  logic [RAND_W-1:0] r_q;
  logic [POS_W-1:0]  p0_q, p1_q, lowpos_q;
  logic [CDF_W-1:0]  c0_q;
  logic [INV_W-1:0]  inv_q;
  logic [P1W-1:0]    prod1_q;
  logic signed [P2W-1:0] prod2_q;

  logic              done_q, valid_q;
  logic [POS_W-1:0]  sample_q, low_q, high_q;

  logic [CW-1:0]     n_eff, mid_w, pick_w;
  logic [CW:0]       sum_w;
  logic              pop, n_ok;
  logic signed [RAND_W+1:0] d_w;
  logic [P1W-1:0]    tfull_w;
  logic [FRACTION_BITS:0] t_w;
  logic signed [POS_W:0]  delta_w;
  logic signed [P2W-1:0]  prod2_d, scaled_w;

  assign q_ready_o = (state_q == S_IDLE);
  assign pop       = q_i.valid && q_ready_o;

  assign n_eff = (32'(entries_in_use_i) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                            : CW'(entries_in_use_i);
  assign n_ok  = (n_eff >= CW'(2));

  assign sum_w = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_w = sum_w[CW:1];

  // Clamp the search result into [1, n-1].
  assign pick_w = (lo_q == n_q) ? n_q - 1'b1 : ((lo_q == '0) ? CW'(1) : lo_q);

  assign d_w      = $signed({2'b00, r_q}) - $signed({1'b0, c0_q});
  assign tfull_w  = prod1_q >> SHIFT;
  assign t_w      = (tfull_w > P1W'(ONE)) ? ONE : tfull_w[FRACTION_BITS:0];
  assign delta_w  = $signed({p1_q[POS_W-1], p1_q}) - $signed({p0_q[POS_W-1], p0_q});
  assign prod2_d  = $signed({1'b0, t_w}) * delta_w;
  assign scaled_w = prod2_q >>> FRACTION_BITS;

  always_comb begin
    mem_we            = 1'b0;
    mem_addr          = '0;
    mem_wdata.position = q_i.req.position;
    mem_wdata.cdf      = q_i.req.cdf;
    mem_wdata.inv_step = q_i.req.inv_step;
    state_d           = state_q;
    case (state_q)
      S_IDLE: begin
        if (pop) begin
          if (q_i.req.kind == KIND_LOAD) begin
            mem_we   = 1'b1;
            mem_addr = AW'(q_i.req.index);
          end else if (n_ok) begin
            state_d = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        if (lo_q < hi_q) begin
          mem_addr = mid_w[AW-1:0];
          state_d  = S_CMP;
        end else begin
          state_d = S_RD0;
        end
      end
      S_CMP:  state_d = S_SRCH;
      S_RD0: begin
        mem_addr = AW'(idx_q - 1'b1);
        state_d  = S_RD1;
      end
      S_RD1: begin
        mem_addr = AW'(idx_q);
        state_d  = S_RD2;
      end
      S_RD2: begin
        mem_addr = '0;
        state_d  = S_RD3;
      end
      S_RD3: begin
        mem_addr = AW'(n_q - 1'b1);
        state_d  = S_MUL1;
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_OUT;
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= ((state_q == S_IDLE) && pop && (q_i.req.kind == KIND_DRAW) && !n_ok) ||
                 (state_q == S_OUT);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (pop && (q_i.req.kind == KIND_DRAW)) begin
          lo_q <= '0;
          hi_q <= n_eff;
          n_q  <= n_eff;
          r_q  <= q_i.req.rnd;
          if (!n_ok) begin
            sample_q <= '0;
            low_q    <= '0;
            high_q   <= '0;
            valid_q  <= 1'b0;
          end
        end
      end
      S_SRCH: begin
        mid_q <= mid_w;
        idx_q <= pick_w;
      end
      S_CMP: begin
        if (rd_q.cdf <= {1'b0, r_q}) begin
          lo_q <= mid_q + 1'b1;
        end else begin
          hi_q <= mid_q;
        end
      end
      S_RD1: begin
        p0_q <= rd_q.position;
        c0_q <= rd_q.cdf;
      end
      S_RD2: begin
        p1_q  <= rd_q.position;
        inv_q <= rd_q.inv_step;
      end
      S_RD3:  lowpos_q <= rd_q.position;
      S_MUL1: begin
        high_q <= rd_q.position;
        if (!d_w[RAND_W+1] && (d_w != '0)) begin
          prod1_q <= P1W'(d_w[RAND_W-1:0]) * P1W'(inv_q);
        end else begin
          prod1_q <= '0;
        end
      end
      S_MUL2: prod2_q <= prod2_d;
      S_OUT: begin
        sample_q <= p0_q + scaled_w[POS_W-1:0];
        low_q    <= lowpos_q;
        valid_q  <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign done_o         = done_q;
  assign sample_value_o = sample_q;
  assign range_low_o    = low_q;
  assign range_high_o   = high_q;
  assign table_valid_o  = valid_q;

  a_search_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> lo_q < hi_q)
    else $error("search compare with empty interval");

  a_pick_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD0 |-> (idx_q >= CW'(1)) && (idx_q < n_q))
    else $error("chosen entry outside [1, n-1]");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !valid_q |-> (sample_q == '0) && (low_q == '0) && (high_q == '0))
    else $error("invalid-table result not all zero");

  a_sample_between: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && valid_q |->
      (($signed(sample_q) >= $signed(p0_q)) && ($signed(sample_q) <= $signed(p1_q))) ||
      (($signed(sample_q) <= $signed(p0_q)) && ($signed(sample_q) >= $signed(p1_q))))
    else $error("sample outside its segment");

endmodule

// ===== rtl/piecewise_cdf_inverse_sampler_core.sv =====
// Inverse-CDF sampler over a loaded piecewise-linear table. A request is taken
// when start is high and busy is low; action_i selects a load (write one entry:
// position, CDF value, reciprocal CDF step) or a draw (map random_value_i to a
// sample). A draw produces exactly one result, shown for a single cycle with
// done_o high; the receiver cannot hold results off, so capture them on that
// cycle. Loads produce no result, and loads to an index at or beyond
// TABLE_DEPTH are dropped. Requests pass through a two-entry queue to the
// execution engine, so busy rises only when that queue is full. A load leaves
// the engine idle and ready for the next request. A draw on a table with fewer
// than two entries in use returns all zeros without a search. Otherwise the
// binary search reads the table through its single memory port, each step
// passing through a search state and a compare state. Table entries have no
// reset and there is no clearing pass: draw only over entries that were
// loaded. Write the entries_in_use register through the cfg channel only
// while no request is outstanding; cfg_ready_o is always high.
module piecewise_cdf_inverse_sampler_core
  import pcdf_pkg::*;
#(
  parameter int TABLE_DEPTH   = DEFAULT_TABLE_DEPTH,
  parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              start,
  output logic              busy,
  input  logic              action_i,
  input  logic [IDX_W-1:0]  entry_index_i,
  input  logic [POS_W-1:0]  entry_position_i,
  input  logic [CDF_W-1:0]  entry_cdf_i,
  input  logic [INV_W-1:0]  entry_inverse_step_i,
  input  logic [RAND_W-1:0] random_value_i,
  // configuration channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CNT_W-1:0]  cfg_entries_in_use_i,
  // result strobe and payload
  output logic              done_o,
  output logic [POS_W-1:0]  sample_value_o,
  output logic [POS_W-1:0]  range_low_o,
  output logic [POS_W-1:0]  range_high_o,
  output logic              table_valid_o
);

  qitem_t           q_item;
  logic             q_ready;
  logic [CNT_W-1:0] entries_q;

  // The register is always writable; the user keeps writes to idle periods, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      entries_q <= cfg_entries_in_use_i;
    end
  end

  // Front end: accept, drop out-of-range loads, queue.
  pcdf_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .action_i             (action_i),
    .entry_index_i        (entry_index_i),
    .entry_position_i     (entry_position_i),
    .entry_cdf_i          (entry_cdf_i),
    .entry_inverse_step_i (entry_inverse_step_i),
    .random_value_i       (random_value_i),
    .q_o                  (q_item),
    .q_ready_i            (q_ready)
  );

  // Back end: table memory, search and interpolation.
  pcdf_back #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_i              (q_item),
    .q_ready_o        (q_ready),
    .entries_in_use_i (entries_q),
    .done_o           (done_o),
    .sample_value_o   (sample_value_o),
    .range_low_o      (range_low_o),
    .range_high_o     (range_high_o),
    .table_valid_o    (table_valid_o)
  );

endmodule
